// ----- rtl/core/lsfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfb_pkg
// Shared types and constants of the LED strip frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfb_pkg;

  localparam int unsigned MaxPixels = 64;
  localparam int unsigned PixIdxW   = $clog2(MaxPixels);
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RowW      = 3 * ByteW;
  localparam int unsigned CntW      = 7;
  localparam int unsigned SlotW     = 2;
  localparam int unsigned PosW      = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InIdxW    = 6;

  localparam logic [ByteW-1:0] StartByte   = 8'h00;
  localparam logic [ByteW-1:0] PixelHeader = 8'hE3;
  localparam logic [ByteW-1:0] EndByte     = 8'hFF;
  localparam logic [PosW-1:0]  StartBytes  = 9'd4;
  localparam logic [PosW-1:0]  EndLastOff  = 9'd3;
  localparam logic [CntW-1:0]  MaxCount    = CntW'(MaxPixels);

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_START     = 2'd2,
    OP_TICK      = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_COUNT = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_RED_SLOT    = 3'd2,
    REG_GREEN_SLOT  = 3'd3,
    REG_BLUE_SLOT   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } seq_state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [InIdxW-1:0] pixel_index;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
  } cmd_t;

  typedef struct packed {
    logic             out_valid;
    logic [ByteW-1:0] out_byte;
    logic             frame_last;
    logic             busy_res;
    logic             rejected;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]  pixel_count;
    logic [ByteW-1:0] brightness;
    logic [SlotW-1:0] red_slot;
    logic [SlotW-1:0] green_slot;
    logic [SlotW-1:0] blue_slot;
  } cfg_t;

  typedef struct packed {
    logic               rd_en;
    logic [PixIdxW-1:0] rd_addr;
    logic               wr_en;
    logic [PixIdxW-1:0] wr_addr;
    logic [RowW-1:0]    wr_data;
    logic               clear;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsfb_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lsfb_cmd_if
// Command channel: valid/ready handshake with a command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfb_cmd_if
  import lsfb_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lsfb_res_if.sv -----
// ----------------------------------------------------------------------------
// lsfb_res_if
// Result channel: valid/ready handshake with a result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfb_res_if
  import lsfb_pkg::*;
();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lsfb_ram.sv -----
// ----------------------------------------------------------------------------
// lsfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsfb_pixel_mem.sv -----
// ----------------------------------------------------------------------------
// lsfb_pixel_mem
// Pixel row store: one 24-bit row per LED, with per-row valid bits so that
// reset and clear take effect at once; an invalid row reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfb_pixel_mem
  import lsfb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mem_req_t        req_i,
  output logic     [RowW-1:0] rdata_o
);

  logic [MaxPixels-1:0] row_vld_q;
  logic [MaxPixels-1:0] row_vld_d;
  logic                 rd_vld_q;
  logic [RowW-1:0]      ram_rdata;

  lsfb_ram #(
    .Width (RowW),
    .Depth (MaxPixels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    row_vld_d = row_vld_q;
    if (req_i.clear) begin
      row_vld_d = '0;
    end else if (req_i.wr_en) begin
      row_vld_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      row_vld_q <= row_vld_d;
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = ram_rdata & {RowW{rd_vld_q}};

endmodule

`default_nettype wire

// ----- rtl/core/lsfb_seq.sv -----
// ----------------------------------------------------------------------------
// lsfb_seq
// Command sequencer: issues the row read, then builds the result, writes
// back merged pixel rows, steps the frame position and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfb_seq
  import lsfb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  lsfb_cmd_if.sink             cmd,
  lsfb_res_if.source           res,
  output mem_req_t             mem_req_o,
  input  wire logic [RowW-1:0] mem_rdata_i
);

  seq_state_e       state_q, state_d;
  cmd_t             cmd_q;
  logic             frame_active_q, frame_active_d;
  logic [PosW-1:0]  frame_pos_q, frame_pos_d;
  res_t             res_q, res_d;
  logic             res_full_q, res_full_d;

  logic             accept;
  logic             load;
  logic [CntW-1:0]  eff_count;
  logic [PosW-1:0]  body_end;
  logic [PosW-1:0]  body_off;
  logic [1:0]       sub_sel;
  logic [ByteW-1:0] raw_byte;
  logic [2*ByteW-1:0] product;
  logic [ByteW-1:0] color_byte;
  logic [RowW-1:0]  merged_row;
  logic             idx_in_range;
  logic             set_write;

  function automatic logic [RowW-1:0] put_byte(input logic [RowW-1:0]  row,
                                               input logic [SlotW-1:0] slot,
                                               input logic [ByteW-1:0] val);
    logic [RowW-1:0] r;
    r = row;
    case (slot)
      2'd0:    r[0*ByteW +: ByteW] = val;
      2'd1:    r[1*ByteW +: ByteW] = val;
      2'd2:    r[2*ByteW +: ByteW] = val;
      default: r = row;
    endcase
    return r;
  endfunction

  assign eff_count = (cfg_i.pixel_count > MaxCount) ? MaxCount : cfg_i.pixel_count;
  assign body_end  = StartBytes + {eff_count, 2'b00};
  assign body_off  = frame_pos_q - StartBytes;
  assign sub_sel   = body_off[1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd.valid) state_d = ST_PROC;
      ST_PROC: if (!res_full_q || res.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready         = 1'b0;
    accept            = 1'b0;
    load              = 1'b0;
    mem_req_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd.ready         = 1'b1;
        accept            = cmd.valid;
        mem_req_o.rd_en   = cmd.valid && ((cmd.payload.opcode == OP_SET_PIXEL) ||
                                          (cmd.payload.opcode == OP_TICK));
        mem_req_o.rd_addr = (cmd.payload.opcode == OP_SET_PIXEL)
                          ? PixIdxW'(cmd.payload.pixel_index)
                          : body_off[PixIdxW+1:2];
      end
      ST_PROC: begin
        load              = !res_full_q || res.ready;
        mem_req_o.wr_en   = load && set_write;
        mem_req_o.wr_addr = PixIdxW'(cmd_q.pixel_index);
        mem_req_o.wr_data = merged_row;
        mem_req_o.clear   = load && !frame_active_q && (cmd_q.opcode == OP_CLEAR);
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  assign idx_in_range = {1'b0, cmd_q.pixel_index} < eff_count;
  assign set_write    = !frame_active_q && (cmd_q.opcode == OP_SET_PIXEL) && idx_in_range;

  always_comb begin
    merged_row = mem_rdata_i;
    if (cfg_i.red_slot != 2'd3) begin
      merged_row = put_byte(merged_row, cfg_i.red_slot, cmd_q.red);
    end
    if (cfg_i.green_slot != 2'd3) begin
      merged_row = put_byte(merged_row, cfg_i.green_slot, cmd_q.green);
    end
    if (cfg_i.blue_slot != 2'd3) begin
      merged_row = put_byte(merged_row, cfg_i.blue_slot, cmd_q.blue);
    end
  end

  always_comb begin
    case (sub_sel)
      2'd1:    raw_byte = mem_rdata_i[0*ByteW +: ByteW];
      2'd2:    raw_byte = mem_rdata_i[1*ByteW +: ByteW];
      2'd3:    raw_byte = mem_rdata_i[2*ByteW +: ByteW];
      default: raw_byte = '0;
    endcase
    product    = raw_byte * cfg_i.brightness;
    color_byte = (cfg_i.brightness != '0) ? product[2*ByteW-1:ByteW] : raw_byte;
  end

  // result and frame update
  always_comb begin
    res_d          = '0;
    frame_active_d = frame_active_q;
    frame_pos_d    = frame_pos_q;
    if (cmd_q.opcode != OP_TICK) begin
      if (frame_active_q) begin
        res_d.rejected = 1'b1;
        res_d.busy_res = 1'b1;
      end else if (cmd_q.opcode == OP_START) begin
        frame_active_d = 1'b1;
        frame_pos_d    = '0;
        res_d.busy_res = 1'b1;
      end
    end else if (frame_active_q) begin
      res_d.out_valid = 1'b1;
      if (frame_pos_q < StartBytes) begin
        res_d.out_byte = StartByte;
      end else if (frame_pos_q < body_end) begin
        res_d.out_byte = (sub_sel == 2'd0) ? PixelHeader : color_byte;
      end else begin
        res_d.out_byte   = EndByte;
        res_d.frame_last = (frame_pos_q - body_end) >= EndLastOff;
      end
      if (res_d.frame_last) begin
        frame_active_d = 1'b0;
        frame_pos_d    = '0;
      end else begin
        frame_pos_d    = frame_pos_q + 1'b1;
        res_d.busy_res = 1'b1;
      end
    end
  end

  assign res_full_d = load ? 1'b1 : (res_full_q && !res.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_active_q <= 1'b0;
      frame_pos_q    <= '0;
      res_full_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_full_q <= res_full_d;
      if (load) begin
        frame_active_q <= frame_active_d;
        frame_pos_q    <= frame_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd.payload;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res.valid   = res_full_q;
  assign res.payload = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/led_strip_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// led_strip_frame_builder_unit
// Serial LED strip frame builder: pixel store, color order and brightness
// registers, and a byte-per-tick frame sequencer.
// ----------------------------------------------------------------------------
// Flow: the command is registered in the accept state and the result in
//   the process state that every command passes through; a full result
//   holds off, and a new command is taken only back in the accept state.
// Reset: registers take their defaults and all pixel rows read as zero at
//   once through per-row valid bits; clear likewise takes one command.
`default_nettype none

module led_strip_frame_builder_unit
  import lsfb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  lsfb_cmd_if.sink                 cmd,
  lsfb_res_if.source               res
);

  cfg_t            cfg_q;
  mem_req_t        mem_req;
  logic [RowW-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_count <= CntW'(35);
      cfg_q.brightness  <= '0;
      cfg_q.red_slot    <= SlotW'(2);
      cfg_q.green_slot  <= SlotW'(1);
      cfg_q.blue_slot   <= SlotW'(0);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PIXEL_COUNT: cfg_q.pixel_count <= cfg_wdata_i[CntW-1:0];
        REG_BRIGHTNESS:  cfg_q.brightness  <= cfg_wdata_i[ByteW-1:0];
        REG_RED_SLOT:    cfg_q.red_slot    <= cfg_wdata_i[SlotW-1:0];
        REG_GREEN_SLOT:  cfg_q.green_slot  <= cfg_wdata_i[SlotW-1:0];
        REG_BLUE_SLOT:   cfg_q.blue_slot   <= cfg_wdata_i[SlotW-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  lsfb_pixel_mem u_pixel_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  lsfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd         (cmd),
    .res         (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule

`default_nettype wire
